// ----- rtl/core/fir_pkg.sv -----
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, types and helpers for the FIR convolution block.
// ----------------------------------------------------------------------------
package fir_pkg;

  // sizing
  localparam int MAX_TAPS       = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int PROD_BITS      = 2 * SAMPLE_BITS;
  localparam int RESULT_BITS    = 40;
  localparam int VALUE_BITS     = 16;
  localparam int TAP_FIELD_BITS = 5;
  localparam int CFG_BITS       = 6;

  localparam int TAP_IDX_BITS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAPS_BITS     = $clog2(MAX_TAPS + 1);
  localparam int IDX_CMP_BITS  = (TAP_IDX_BITS > TAP_FIELD_BITS) ? TAP_IDX_BITS + 1
                                                                  : TAP_FIELD_BITS + 1;
  // edges from a shift until the head of the sum chain holds the full sum
  localparam int SETTLE_CYCLES = MAX_TAPS + 1;
  localparam int CNT_BITS      = $clog2(SETTLE_CYCLES + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [RESULT_BITS-1:0] result_t;

  // request codes
  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROCESS = 1'b1
  } fir_cmd_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } fir_state_t;

  // control bundle broadcast to the cell row
  typedef struct packed {
    logic                    shift_en;
    logic                    clear;
    sample_t                 shift_data;
    logic                    coef_we;
    logic [TAP_IDX_BITS-1:0] coef_addr;
    sample_t                 coef_data;
    logic [TAPS_BITS-1:0]    taps;
  } fir_cell_ctl_t;

  // clamp the tap count register to 1..MAX_TAPS
  function automatic logic [TAPS_BITS-1:0] taps_in_use(input logic [CFG_BITS-1:0] cnt);
    int unsigned v;
    v = int'(cnt);
    if (v == 0) begin
      return TAPS_BITS'(1);
    end
    if (v > MAX_TAPS) begin
      return TAPS_BITS'(MAX_TAPS);
    end
    return TAPS_BITS'(v);
  endfunction

endpackage

// ----- rtl/core/fir_if.sv -----
// ----------------------------------------------------------------------------
// fir_if
// Valid/ready channels for FIR requests and FIR results.
// ----------------------------------------------------------------------------

// request channel: coefficient loads and signal samples
interface fir_in_if
  import fir_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [TAP_FIELD_BITS-1:0] tap_index;
  logic signed [VALUE_BITS-1:0] value;
  logic                      last_sample;

  modport source (output valid, cmd, tap_index, value, last_sample, input ready);
  modport sink   (input valid, cmd, tap_index, value, last_sample, output ready);
endinterface

// result channel: convolution outputs
interface fir_out_if
  import fir_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] result_value;
  logic                          last_out;

  modport source (output valid, result_value, last_out, input ready);
  modport sink   (input valid, result_value, last_out, output ready);
endinterface

// ----- rtl/core/fir_cell.sv -----
// ----------------------------------------------------------------------------
// fir_cell
// One tap of the FIR row: holds a coefficient and a delayed sample, forms
// their product and adds it onto the partial sum coming from the next cell.
// ----------------------------------------------------------------------------
module fir_cell
  import fir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [TAP_IDX_BITS-1:0] cell_idx,
  input  fir_cell_ctl_t           ctl,
  input  sample_t                 samp_in,
  output sample_t                 samp_out,
  input  result_t                 acc_in,
  output result_t                 acc_out
);

  sample_t coef_r, coef_nxt;
  sample_t samp_r, samp_nxt;
  prod_t   prod_r, prod_nxt;
  result_t acc_r,  acc_nxt;
  logic    tap_en;

  // taps beyond the count in use contribute nothing
  assign tap_en = TAPS_BITS'(cell_idx) < ctl.taps;

  // coefficient slot
  always_comb begin
    coef_nxt = coef_r;
    if (ctl.coef_we && (ctl.coef_addr == cell_idx)) begin
      coef_nxt = ctl.coef_data;
    end
  end

  // delay line stage
  always_comb begin
    samp_nxt = samp_r;
    if (ctl.clear) begin
      samp_nxt = '0;
    end else if (ctl.shift_en) begin
      samp_nxt = samp_in;
    end
  end

  // product and partial sum
  always_comb begin
    prod_nxt = tap_en ? (PROD_BITS'(coef_r) * PROD_BITS'(samp_r)) : '0;
    acc_nxt  = acc_in + RESULT_BITS'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r <= '0;
    end else begin
      samp_r <= samp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign samp_out = samp_r;
  assign acc_out  = acc_r;

endmodule

// ----- rtl/core/fir_ctrl.sv -----
// ----------------------------------------------------------------------------
// fir_ctrl
// Sequencer for the FIR row: decodes requests, steps the delay line through
// the sample and its zero-fed tail, and holds the result register.
// ----------------------------------------------------------------------------
module fir_ctrl
  import fir_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  fir_in_if.sink              in_chan,
  fir_out_if.source           out_chan,
  input  result_t             acc_head,
  output fir_cell_ctl_t       ctl
);

  fir_state_t state_r, state_nxt;

  logic [CFG_BITS-1:0]  tap_count_r, tap_count_nxt;
  logic [TAPS_BITS-1:0] taps_r, taps_nxt;
  logic [TAPS_BITS-1:0] tail_r, tail_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                    in_accept;
  logic                    is_process;
  logic                    is_load;
  logic                    capture;
  logic                    out_take;
  logic [IDX_CMP_BITS-1:0] idx_wide;
  logic                    idx_ok;
  logic [TAPS_BITS-1:0]    taps_new;

  // handshake decode
  assign in_accept  = in_chan.valid && in_chan.ready;
  assign is_process = in_accept && (in_chan.cmd == CMD_PROCESS);
  assign is_load    = in_accept && (in_chan.cmd == CMD_LOAD);
  assign capture    = (state_r == ST_WORK) && (cnt_r == '0) &&
                      (!out_valid_r || out_chan.ready);
  assign out_take   = out_valid_r && out_chan.ready;
  assign idx_wide   = IDX_CMP_BITS'(in_chan.tap_index);
  assign idx_ok     = idx_wide < IDX_CMP_BITS'(MAX_TAPS);
  assign taps_new   = taps_in_use(tap_count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_process) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (capture && (tail_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs towards the ports and the cell row
  always_comb begin
    in_chan.ready  = 1'b0;
    ctl.shift_en   = 1'b0;
    ctl.clear      = 1'b0;
    ctl.shift_data = '0;
    ctl.coef_we    = is_load && idx_ok;
    ctl.coef_addr  = TAP_IDX_BITS'(idx_wide);
    ctl.coef_data  = SAMPLE_BITS'(in_chan.value);
    ctl.taps       = taps_r;
    case (state_r)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_chan.ready  = rst_n;
        ctl.shift_en   = is_process;
        ctl.shift_data = SAMPLE_BITS'(in_chan.value);
      end
      ST_WORK: begin
        ctl.shift_en = capture && (tail_r != '0);
        ctl.clear    = capture && (tail_r == '0) && last_r;
      end
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  // sequencing registers
  always_comb begin
    tap_count_nxt = cfg_we ? cfg_wdata : tap_count_r;
    taps_nxt      = taps_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    if (is_process) begin
      taps_nxt = taps_new;
      last_nxt = in_chan.last_sample;
      tail_nxt = in_chan.last_sample ? (taps_new - TAPS_BITS'(1)) : '0;
      cnt_nxt  = CNT_BITS'(SETTLE_CYCLES);
    end else if (capture) begin
      if (tail_r != '0) begin
        tail_nxt = tail_r - TAPS_BITS'(1);
        cnt_nxt  = CNT_BITS'(SETTLE_CYCLES);
      end
    end else if ((state_r == ST_WORK) && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (capture) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = acc_head;
      out_last_nxt  = last_r && (tail_r == '0);
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= CFG_BITS'(1);
      taps_r      <= TAPS_BITS'(1);
      tail_r      <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_count_r <= tap_count_nxt;
      taps_r      <= taps_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.last_out     = out_last_r;

  // a stalled result holds the sequencer and its tail count
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORK && cnt_r == '0 && out_valid_r && !out_chan.ready)
    |=> (state_r == ST_WORK && $stable(tail_r)))
    else $error("sequencer moved on while result stalled");

  // a last sample schedules one tail output per extra tap
  a_tail_len: assert property (@(posedge clk) disable iff (!rst_n)
    (is_process && in_chan.last_sample) |=> (tail_r == taps_r - TAPS_BITS'(1)))
    else $error("tail length does not match tap count");

  // clearing the delay line never coincides with a shift
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |-> !ctl.shift_en)
    else $error("delay line cleared and shifted together");

  // the final capture of an item returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (capture && tail_r == '0) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("sequencer did not finish after final output");

endmodule

// ----- rtl/core/fir_convolution.sv -----
// ----------------------------------------------------------------------------
// fir_convolution
// Streaming FIR filter giving the full linear convolution of a sample stream
// with a loaded impulse response.
// ----------------------------------------------------------------------------
// A coefficient load request is taken while idle and yields no result. A
// sample request shifts the sample into a row of MAX_TAPS cells, each holding
// one coefficient, one delayed sample and one multiplier; the products add up
// along a registered chain running from the far cell to cell 0, so a result
// is ready once the full sum reaches cell 0, and the block takes no new
// request while it works. A sample marked last also gives one zero-fed tail
// result per tap in use beyond the first (tap_count clamped to 1..MAX_TAPS),
// after which the delay line is cleared. Results sit in an output register,
// so the next request is taken while a result waits. tap_count is sampled
// when a sample request is taken; write it only while the block is idle.
// Results are exact 40-bit Q30 sums.
// ----------------------------------------------------------------------------
module fir_convolution
  import fir_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  fir_in_if.sink              in_chan,
  fir_out_if.source           out_chan
);

  fir_cell_ctl_t ctl;
  sample_t       samp_chain [MAX_TAPS];
  result_t       acc_chain  [MAX_TAPS+1];

  // sequencer and result register
  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .acc_head  (acc_chain[0]),
    .ctl       (ctl)
  );

  // chain ends
  assign samp_chain[0]        = ctl.shift_data;
  assign acc_chain[MAX_TAPS]  = '0;

  // row of tap cells
  for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
    sample_t samp_fwd;

    fir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (TAP_IDX_BITS'(g)),
      .ctl      (ctl),
      .samp_in  (samp_chain[g]),
      .samp_out (samp_fwd),
      .acc_in   (acc_chain[g+1]),
      .acc_out  (acc_chain[g])
    );

    if (g < MAX_TAPS - 1) begin : g_fwd
      assign samp_chain[g+1] = samp_fwd;
    end
  end

endmodule
